### sv/stp_pkg.sv
`default_nettype none
package stp_pkg;

  localparam int unsigned PAD_SLOTS = 4;
  localparam int unsigned PAD_W = 2;
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned SPAN_W = 24;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(600);
  localparam logic [SPAN_W-1:0] PRESS_RESET = SPAN_W'(30000);
  localparam logic [SPAN_W-1:0] HOLDOFF_RESET = SPAN_W'(1000);

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_PAD0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_PAD1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_PAD2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_PAD3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRESS_DURATION = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RETRIGGER_HOLDOFF = 3'd5;

  typedef struct packed {
    logic [PAD_SLOTS-1:0][LEVEL_W-1:0] threshold;
    logic [SPAN_W-1:0] press_duration;
    logic [SPAN_W-1:0] retrigger_holdoff;
  } cfg_t;

  typedef struct packed {
    logic strike;
    logic held;
    logic held_next;
  } lane_status_t;

endpackage
`default_nettype wire

### sv/stp_in_if.sv
`default_nettype none
interface stp_in_if;
  logic valid;
  logic ready;
  logic [stp_pkg::PAD_W-1:0] pad_index;
  logic [stp_pkg::LEVEL_W-1:0] level;
  logic [stp_pkg::TIME_W-1:0] timestamp;

  modport source (output valid, output pad_index, output level, output timestamp,
                  input ready);
  modport sink (input valid, input pad_index, input level, input timestamp,
                output ready);
endinterface
`default_nettype wire

### sv/stp_out_if.sv
`default_nettype none
interface stp_out_if;
  logic valid;
  logic ready;
  logic [stp_pkg::PAD_W-1:0] pad_echo;
  logic strike;
  logic held;
  logic [stp_pkg::PAD_SLOTS-1:0] held_vector;

  modport source (output valid, output pad_echo, output strike, output held,
                  output held_vector, input ready);
  modport sink (input valid, input pad_echo, input strike, input held,
                input held_vector, output ready);
endinterface
`default_nettype wire

### sv/stp_cfg_if.sv
`default_nettype none
interface stp_cfg_if;
  logic valid;
  logic ready;
  logic [stp_pkg::REG_IDX_W-1:0] index;
  logic [stp_pkg::REG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/stp_cfg.sv
`default_nettype none
module stp_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  stp_cfg_if.sink       cfg,
  output stp_pkg::cfg_t regs
);

  stp_pkg::cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(stp_pkg::PAD_SLOTS); i++) begin
        regs_q.threshold[i] <= stp_pkg::THRESHOLD_RESET;
      end
      regs_q.press_duration <= stp_pkg::PRESS_RESET;
      regs_q.retrigger_holdoff <= stp_pkg::HOLDOFF_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        stp_pkg::REG_THRESHOLD_PAD0: begin
          regs_q.threshold[0] <= cfg.data[stp_pkg::LEVEL_W-1:0];
        end
        stp_pkg::REG_THRESHOLD_PAD1: begin
          regs_q.threshold[1] <= cfg.data[stp_pkg::LEVEL_W-1:0];
        end
        stp_pkg::REG_THRESHOLD_PAD2: begin
          regs_q.threshold[2] <= cfg.data[stp_pkg::LEVEL_W-1:0];
        end
        stp_pkg::REG_THRESHOLD_PAD3: begin
          regs_q.threshold[3] <= cfg.data[stp_pkg::LEVEL_W-1:0];
        end
        stp_pkg::REG_PRESS_DURATION: begin
          regs_q.press_duration <= cfg.data[stp_pkg::SPAN_W-1:0];
        end
        stp_pkg::REG_RETRIGGER_HOLDOFF: begin
          regs_q.retrigger_holdoff <= cfg.data[stp_pkg::SPAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/stp_lane.sv
`default_nettype none
module stp_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sel,
  input  wire logic [stp_pkg::LEVEL_W-1:0]   level,
  input  wire logic [stp_pkg::TIME_W-1:0]    now,
  input  wire logic [stp_pkg::LEVEL_W-1:0]   threshold,
  input  wire logic [stp_pkg::SPAN_W-1:0]    press_duration,
  input  wire logic [stp_pkg::SPAN_W-1:0]    retrigger_holdoff,
  output stp_pkg::lane_status_t              status
);

  logic                        was_active;
  logic [stp_pkg::TIME_W-1:0]  press_end;
  logic [stp_pkg::TIME_W-1:0]  holdoff_end;
  logic                        held_flag;

  logic                        active;
  logic                        fire;
  logic [stp_pkg::TIME_W:0]    press_sum;
  logic [stp_pkg::TIME_W:0]    holdoff_sum;
  logic [stp_pkg::TIME_W-1:0]  press_end_next;
  logic [stp_pkg::TIME_W-1:0]  holdoff_end_next;
  logic                        held_now;

  // Sums saturate at the top of the time range.
  always_comb begin
    active = level >= threshold;
    fire = active && !was_active && (now >= holdoff_end);
    press_sum = {1'b0, now} + (stp_pkg::TIME_W + 1)'(press_duration);
    holdoff_sum = {1'b0, now} + (stp_pkg::TIME_W + 1)'(retrigger_holdoff);
    press_end_next = press_end;
    holdoff_end_next = holdoff_end;
    if (fire) begin
      press_end_next = press_sum[stp_pkg::TIME_W] ? '1 : press_sum[stp_pkg::TIME_W-1:0];
      holdoff_end_next = holdoff_sum[stp_pkg::TIME_W] ? '1 :
                         holdoff_sum[stp_pkg::TIME_W-1:0];
    end
    held_now = now < press_end_next;
    status.strike = sel && fire;
    status.held = sel && held_now;
    status.held_next = sel ? held_now : held_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_active <= 1'b0;
      press_end <= '0;
      holdoff_end <= '0;
      held_flag <= 1'b0;
    end else if (sel) begin
      was_active <= active;
      press_end <= press_end_next;
      holdoff_end <= holdoff_end_next;
      held_flag <= held_now;
    end
  end

endmodule
`default_nettype wire

### sv/strike_trigger_pulse_stretch.sv
`default_nettype none
// A sample request is registered in the sample register on acceptance, and its result is
// registered in the output register when the sample advances. One sample is taken every
// cycle unless results stall; the per-channel compare and saturating add set the cycle.
// A stalled result holds the sample register, which in turn stalls the input.
// Reset restores the default thresholds and times and clears all channel state and flags.
module strike_trigger_pulse_stretch #(
  parameter int unsigned PAD_COUNT = 4
) (
  input wire logic  clk,
  input wire logic  rst,
  stp_in_if.sink    samples,
  stp_out_if.source results,
  stp_cfg_if.sink   cfg
);

  stp_pkg::cfg_t regs;

  logic                             s1_valid;
  logic [stp_pkg::PAD_W-1:0]        s1_pad;
  logic [stp_pkg::LEVEL_W-1:0]      s1_level;
  logic [stp_pkg::TIME_W-1:0]       s1_time;
  logic                             advance;

  logic                             out_valid;
  logic [stp_pkg::PAD_W-1:0]        out_pad;
  logic                             out_strike;
  logic                             out_held;
  logic [stp_pkg::PAD_SLOTS-1:0]    out_vector;

  stp_pkg::lane_status_t            status [stp_pkg::PAD_SLOTS];
  logic [stp_pkg::PAD_SLOTS-1:0]    held_vector_next;

  stp_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  for (genvar g = 0; g < int'(stp_pkg::PAD_SLOTS); g++) begin : g_lane
    if (g < int'(PAD_COUNT)) begin : g_used
      stp_lane u_lane (
        .clk               (clk),
        .rst               (rst),
        .sel               (advance && (s1_pad == stp_pkg::PAD_W'(g))),
        .level             (s1_level),
        .now               (s1_time),
        .threshold         (regs.threshold[g]),
        .press_duration    (regs.press_duration),
        .retrigger_holdoff (regs.retrigger_holdoff),
        .status            (status[g])
      );
    end else begin : g_unused
      assign status[g] = '0;
    end
    assign held_vector_next[g] = status[g].held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_pad <= samples.pad_index;
      s1_level <= samples.level;
      s1_time <= samples.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pad <= s1_pad;
      out_strike <= status[s1_pad].strike;
      out_held <= status[s1_pad].held;
      out_vector <= held_vector_next;
    end
  end

  assign results.valid = out_valid;
  assign results.pad_echo = out_pad;
  assign results.strike = out_strike;
  assign results.held = out_held;
  assign results.held_vector = out_vector;

endmodule
`default_nettype wire
